FILE: src/openpgp_packet_stream_scanner_top_defines.svh
// assertion macros for the openpgp packet stream scanner
`ifndef OPENPGP_PACKET_STREAM_SCANNER_TOP_DEFINES_SVH
`define OPENPGP_PACKET_STREAM_SCANNER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define PGPSS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define PGPSS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PGPSS_ASSERT_ALWAYS(label, cond, msg)
`define PGPSS_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

FILE: src/pgpss_pkg.sv
// shared types and constants of the openpgp packet stream scanner
`default_nettype none
package pgpss_pkg;

  // widths
  localparam int KEY_LENGTH_BITS = 24;
  localparam int CFG_W           = 24;
  localparam int TAG_W           = 6;
  localparam int LEN_W           = 32;
  localparam int END_W           = 33;
  localparam int STATUS_W        = 2;
  localparam int LBL_W           = 3;
  localparam int SEEN_W          = 3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_NEW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_OLD = 2'd2;

  // packet tags of interest
  localparam logic [TAG_W-1:0] TAG_SIGNATURE  = 6'd2;
  localparam logic [TAG_W-1:0] TAG_PUBLIC_KEY = 6'd6;
  localparam logic [TAG_W-1:0] TAG_USER_ID    = 6'd13;

  // seen flag positions
  localparam int SEEN_PUBKEY = 0;
  localparam int SEEN_USERID = 1;
  localparam int SEEN_SIG    = 2;

  // header byte fields and length byte thresholds
  localparam int          NEW_FMT_BIT     = 6;
  localparam logic [1:0]  OLD_LEN_ONE     = 2'd0;
  localparam logic [1:0]  OLD_LEN_TWO     = 2'd1;
  localparam logic [1:0]  OLD_LEN_FOUR    = 2'd2;
  localparam logic [1:0]  OLD_LEN_INDEF   = 2'd3;
  localparam logic [7:0]  LEN_TWO_START   = 8'd192;
  localparam logic [7:0]  LEN_PART_START  = 8'd224;
  localparam logic [7:0]  LEN_FIVE_MARK   = 8'hFF;
  localparam logic [LBL_W-1:0] LBL_ONE    = 3'd1;
  localparam logic [LBL_W-1:0] LBL_TWO    = 3'd2;
  localparam logic [LBL_W-1:0] LBL_FOUR   = 3'd4;
  localparam logic [KEY_LENGTH_BITS-1:0] OFFSET_MAX = {KEY_LENGTH_BITS{1'b1}};

  // parser phase
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NEWLEN = 3'd1,
    PH_TWO    = 3'd2,
    PH_MULTI  = 3'd3,
    PH_BODY   = 3'd4,
    PH_HALT   = 3'd5
  } phase_t;

  // word held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  // result word
  typedef struct packed {
    logic [TAG_W-1:0]    hdr_tag;
    logic [LEN_W-1:0]    body_len;
    logic [END_W-1:0]    packet_end;
    logic                key_done;
    logic [STATUS_W-1:0] status;
  } result_t;

  // result toward the output register
  typedef struct packed {
    logic    valid;
    result_t word;
  } res_t;

endpackage
`default_nettype wire

FILE: src/pgpss_if.sv
// valid/ready channel interfaces for input bytes and result words
`default_nettype none
interface pgpss_in_if;
  import pgpss_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface pgpss_out_if;
  import pgpss_pkg::*;
  logic                valid;
  logic                ready;
  logic [TAG_W-1:0]    hdr_tag;
  logic [LEN_W-1:0]    body_len;
  logic [END_W-1:0]    packet_end;
  logic                key_done;
  logic [STATUS_W-1:0] status;
  modport source (output valid, output hdr_tag, output body_len,
                  output packet_end, output key_done, output status, input ready);
  modport sink   (input valid, input hdr_tag, input body_len,
                  input packet_end, input key_done, input status, output ready);
endinterface
`default_nettype wire

FILE: src/pgpss_in_stage.sv
// input register holding one byte word ahead of the parser
`default_nettype none
module pgpss_in_stage (
  input  wire              clk,
  input  wire              rst_n,
  pgpss_in_if.sink         in_ch,
  input  wire              take_i,
  output pgpss_pkg::item_t item_o
);
  import pgpss_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       first_r;
  logic       accept;

  // free when empty or when the parser takes the held word
  assign in_ch.ready = !valid_r || take_i;
  assign accept      = in_ch.valid && in_ch.ready;

  // occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r  <= in_ch.data_byte;
      first_r <= in_ch.first_byte;
    end
  end

  assign item_o = '{valid: valid_r, data_byte: byte_r, first_byte: first_r};

endmodule
`default_nettype wire

FILE: src/pgpss_parser.sv
// header decode state machine, body skip and key completion tracking
`default_nettype none
module pgpss_parser (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [pgpss_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire pgpss_pkg::item_t        item_i,
  input  wire                          take_i,
  output pgpss_pkg::res_t              res_o
);
  import pgpss_pkg::*;

  // registers
  logic [CFG_W-1:0]           buf_len_r;
  phase_t                     phase_r, phase_nxt;
  logic [KEY_LENGTH_BITS-1:0] off_r, off_nxt;
  logic [LBL_W-1:0]           lbl_r, lbl_nxt;
  logic [LEN_W-1:0]           acc_r, acc_nxt;
  logic [7:0]                 flb_r, flb_nxt;
  logic [TAG_W-1:0]           tag_r, tag_nxt;
  logic [LEN_W-1:0]           body_r, body_nxt;
  logic [SEEN_W-1:0]          seen_r, seen_nxt;

  // state after an optional first-byte clear
  phase_t                     ph_e;
  logic [KEY_LENGTH_BITS-1:0] off_e, off_inc;
  logic [LBL_W-1:0]           lbl_e, lbl_dec;
  logic [LEN_W-1:0]           acc_e, body_e, body_dec;
  logic [7:0]                 flb_e, b;
  logic [TAG_W-1:0]           tag_e;
  logic [SEEN_W-1:0]          seen_e, seen_fin;

  // decode results
  phase_t                     ph_dec;
  logic                       fin, err, halted, fire, done;
  logic [STATUS_W-1:0]        err_code;
  logic [END_W-1:0]           end_sum;

  assign fire = item_i.valid && take_i;
  assign b    = item_i.data_byte;

  // first byte of a key clears everything
  always_comb begin
    if (item_i.first_byte) begin
      ph_e   = PH_HEADER;
      off_e  = '0;
      lbl_e  = '0;
      acc_e  = '0;
      flb_e  = '0;
      tag_e  = '0;
      body_e = '0;
      seen_e = '0;
    end else begin
      ph_e   = phase_r;
      off_e  = off_r;
      lbl_e  = lbl_r;
      acc_e  = acc_r;
      flb_e  = flb_r;
      tag_e  = tag_r;
      body_e = body_r;
      seen_e = seen_r;
    end
  end

  // saturating offset and down counters
  assign halted   = !(ph_e == PH_HEADER || ph_e == PH_NEWLEN || ph_e == PH_TWO ||
                      ph_e == PH_MULTI || ph_e == PH_BODY);
  assign off_inc  = (off_e < OFFSET_MAX) ? off_e + 1'b1 : off_e;
  assign lbl_dec  = (lbl_e != '0) ? lbl_e - 1'b1 : lbl_e;
  assign body_dec = (body_e != '0) ? body_e - 1'b1 : body_e;

  // per-phase byte decode
  always_comb begin
    ph_dec   = ph_e;
    lbl_nxt  = lbl_e;
    acc_nxt  = acc_e;
    flb_nxt  = flb_e;
    tag_nxt  = tag_e;
    body_nxt = body_e;
    fin      = 1'b0;
    err      = 1'b0;
    err_code = ST_OK;
    unique case (ph_e)
      PH_HEADER: begin
        if (b[NEW_FMT_BIT]) begin
          tag_nxt = b[TAG_W-1:0];
          ph_dec  = PH_NEWLEN;
        end else begin
          tag_nxt = {2'b00, b[5:2]};
          case (b[1:0])
            OLD_LEN_ONE:  lbl_nxt = LBL_ONE;
            OLD_LEN_TWO:  lbl_nxt = LBL_TWO;
            OLD_LEN_FOUR: lbl_nxt = LBL_FOUR;
            default:      lbl_nxt = lbl_e;
          endcase
          if (b[1:0] == OLD_LEN_INDEF) begin
            err      = 1'b1;
            err_code = ST_BAD_OLD;
          end else begin
            acc_nxt = '0;
            ph_dec  = PH_MULTI;
          end
        end
      end
      PH_NEWLEN: begin
        if (b < LEN_TWO_START) begin
          acc_nxt = LEN_W'(b);
          fin     = 1'b1;
        end else if (b < LEN_PART_START) begin
          flb_nxt = b;
          ph_dec  = PH_TWO;
        end else if (b == LEN_FIVE_MARK) begin
          acc_nxt = '0;
          lbl_nxt = LBL_FOUR;
          ph_dec  = PH_MULTI;
        end else begin
          err      = 1'b1;
          err_code = ST_BAD_NEW;
        end
      end
      PH_TWO: begin
        acc_nxt = ((LEN_W'(flb_e) - LEN_W'(LEN_TWO_START)) << 8) + LEN_W'(b)
                  + LEN_W'(LEN_TWO_START);
        fin     = 1'b1;
      end
      PH_MULTI: begin
        acc_nxt = {acc_e[LEN_W-9:0], b};
        lbl_nxt = lbl_dec;
        fin     = (lbl_dec == '0);
      end
      PH_BODY: begin
        body_nxt = body_dec;
        if (body_dec == '0) begin
          ph_dec = PH_HEADER;
        end
      end
      default: begin
        ph_dec = ph_e;
      end
    endcase
  end

  // header completion: end offset, seen flags, key done
  assign end_sum = END_W'(off_inc) + END_W'(acc_nxt);

  always_comb begin
    seen_fin = seen_e;
    if (tag_nxt == TAG_PUBLIC_KEY) seen_fin[SEEN_PUBKEY] = 1'b1;
    if (tag_nxt == TAG_USER_ID)    seen_fin[SEEN_USERID] = 1'b1;
    if (tag_nxt == TAG_SIGNATURE)  seen_fin[SEEN_SIG]    = 1'b1;
  end

  assign done = (seen_fin == {SEEN_W{1'b1}}) || (end_sum >= END_W'(buf_len_r));

  // next state
  always_comb begin
    phase_nxt = ph_dec;
    off_nxt   = halted ? off_e : off_inc;
    seen_nxt  = seen_e;
    if (err) begin
      phase_nxt = PH_HALT;
    end else if (fin) begin
      seen_nxt = seen_fin;
      if (done) begin
        phase_nxt = PH_HALT;
      end else if (acc_nxt == '0) begin
        phase_nxt = PH_HEADER;
      end else begin
        phase_nxt = PH_BODY;
      end
    end
  end

  // result word
  always_comb begin
    res_o.valid           = fire && (fin || err);
    res_o.word.hdr_tag    = tag_nxt;
    res_o.word.body_len   = err ? '0 : acc_nxt;
    res_o.word.packet_end = err ? '0 : end_sum;
    res_o.word.key_done   = !err && done;
    res_o.word.status     = err ? err_code : ST_OK;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r <= '0;
    end else if (cfg_we) begin
      buf_len_r <= cfg_wdata;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      off_r   <= '0;
      lbl_r   <= '0;
      acc_r   <= '0;
      flb_r   <= '0;
      tag_r   <= '0;
      body_r  <= '0;
      seen_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      lbl_r   <= lbl_nxt;
      acc_r   <= acc_nxt;
      flb_r   <= flb_nxt;
      tag_r   <= tag_nxt;
      body_r  <= (fin && !err) ? acc_nxt : body_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/pgpss_out_stage.sv
// output register presenting result words to the receiver
`default_nettype none
module pgpss_out_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire pgpss_pkg::res_t res_i,
  output logic                 take_o,
  pgpss_out_if.source          out_ch
);
  import pgpss_pkg::*;

  logic    valid_r;
  result_t word_r;

  // register is free when empty or being drained
  assign take_o = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_o) begin
      valid_r <= res_i.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (take_o && res_i.valid) begin
      word_r <= res_i.word;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.hdr_tag    = word_r.hdr_tag;
  assign out_ch.body_len   = word_r.body_len;
  assign out_ch.packet_end = word_r.packet_end;
  assign out_ch.key_done   = word_r.key_done;
  assign out_ch.status     = word_r.status;

endmodule
`default_nettype wire

FILE: src/openpgp_packet_stream_scanner_top.sv
// OpenPGP packet stream scanner: binary key bytes in, one word per packet header out.
// in_ch carries one key byte per word, with first_byte marking the start of a new key;
// first_byte clears all scan state before the byte is decoded as a header byte.
// out_ch carries one word per completed header (tag, body length, end offset, key_done)
// or per malformed length (status nonzero, then the scanner ignores bytes until the
// next first_byte). Bytes inside headers that do not complete and body bytes give no word.
// cfg_we/cfg_wdata load buffer_length; write it only while the scanner is idle.
// A byte accepted from in_ch is held in the input register and decoded by the parser,
// and its result word is then registered in the output register.
// Throughput: one byte per cycle while the receiver takes words, bound by the single
// decode step between the input register and the output register.
// When the receiver stalls, the output register holds its word, the input register
// keeps one byte, and in_ch.ready drops once both are full.
// Reset (rst_n low, synchronous) empties both registers, clears buffer_length and
// returns the parser to waiting for a header byte.
`default_nettype none
`include "openpgp_packet_stream_scanner_top_defines.svh"
module openpgp_packet_stream_scanner_top (
  input  wire                        clk,
  input  wire                        rst_n,
  pgpss_in_if.sink                   in_ch,
  pgpss_out_if.source                out_ch,
  input  wire                        cfg_we,
  input  wire [pgpss_pkg::CFG_W-1:0] cfg_wdata
);
  import pgpss_pkg::*;

  item_t item;
  res_t  res;
  logic  take;
  logic  err_word, ok_word, err_clean, end_past;

  // input register
  pgpss_in_stage u_in (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .take_i (take),
    .item_o (item)
  );

  // decode and state
  pgpss_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_i    (item),
    .take_i    (take),
    .res_o     (res)
  );

  // output register
  pgpss_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .res_i  (res),
    .take_o (take),
    .out_ch (out_ch)
  );

  // terms watched by the checks below
  assign err_word  = out_ch.valid && out_ch.status != ST_OK;
  assign ok_word   = out_ch.valid && out_ch.status == ST_OK;
  assign err_clean = out_ch.body_len == '0 && out_ch.packet_end == '0 && !out_ch.key_done;
  assign end_past  = out_ch.packet_end > END_W'(out_ch.body_len);

  // error words carry no length information
  `PGPSS_ASSERT_IMPLY(a_err_zero, err_word, err_clean, "error word with nonzero length fields")
  // a complete header always ends past its own body length
  `PGPSS_ASSERT_IMPLY(a_end_past_len, ok_word, end_past, "packet end not past body length")
  // a held byte that cannot advance blocks new input
  `PGPSS_ASSERT_IMPLY(a_in_blocked, item.valid && !take, !in_ch.ready, "input over a stall")

endmodule
`default_nettype wire
